>>> rtl/core/pnz_pkg.sv
// ----------------------------------------------------------------------------
// pnz_pkg
// Shared constants and types for the 2-D gradient noise pipeline.
// ----------------------------------------------------------------------------
package pnz_pkg;

    // Default configuration
    localparam int TABLE_SIZE_DEF = 256;
    localparam int FRAC_BITS_DEF  = 16;

    // Field widths
    localparam int COORD_W = 32;
    localparam int ENTRY_W = 8;
    localparam int OUT_FRAC = 16;
    localparam int OUT_W    = 18;
    localparam int OUT_MAX  = 131071;
    localparam int OUT_MIN  = -131072;

    // Fade polynomial coefficients: 6t^5 - 15t^4 + 10t^3
    localparam int FADE_K6  = 6;
    localparam int FADE_K15 = 15;
    localparam int FADE_K10 = 10;

    // Item kinds
    localparam logic MODE_COMPUTE = 1'b0;
    localparam logic MODE_WRITE   = 1'b1;

    // Pipeline register stages, numbered 1 (input) to NUM_STAGES (output)
    localparam int NUM_STAGES = 8;
    typedef logic [NUM_STAGES:1] stage_ld_t;

    // Permutation table write strobes, one per read stage
    typedef struct packed {
        logic we_first;   // copy read with the cell x index
        logic we_second;  // copies read with the hashed corner indexes
    } tbl_wr_t;

endpackage

>>> rtl/core/perlin_noise_2d.sv
// Eight register stages lie between the accepting edge and m_valid; the
//   input register is the first.
// Throughput: one beat per cycle while m_ready is high; a stage loads when
//   the next stage is empty or moving, so bubbles close up under output stalls.
// Table-write beats occupy stages 1 and 2 and produce no result beat.
// Reset clears the valid bits only; the permutation table must be loaded.
// ----------------------------------------------------------------------------
// perlin_noise_2d
// Pipelined 2-D gradient noise with a loadable permutation table.
// ----------------------------------------------------------------------------
module perlin_noise_2d
    import pnz_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_mode,
    input  logic signed [COORD_W-1:0] s_x_coord,
    input  logic signed [COORD_W-1:0] s_y_coord,
    input  logic [ENTRY_W-1:0]        s_entry_index,
    input  logic [ENTRY_W-1:0]        s_entry_value,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [OUT_W-1:0]   m_noise_value
);

    localparam int F = FRAC_BITS;

    // Stage valid bits; the last one is the output beat
    logic [NUM_STAGES:1] v_reg;
    logic [NUM_STAGES:1] v_next;
    stage_ld_t           ld;
    tbl_wr_t             wr;

    // Load chain from the output back to the input
    always_comb begin
        ld[NUM_STAGES] = !v_reg[NUM_STAGES] || m_ready;
        for (int k = NUM_STAGES - 1; k >= 1; k--) begin
            ld[k] = !v_reg[k] || ld[k+1];
        end
    end

    assign s_ready = ld[1];

    // Stage 1 input registers and item kind down to stage 2
    logic                      mode1_reg;
    logic                      mode2_reg;
    logic signed [COORD_W-1:0] x1_reg;
    logic signed [COORD_W-1:0] y1_reg;
    logic [ENTRY_W-1:0]        idx1_reg;
    logic [ENTRY_W-1:0]        val1_reg;

    always_ff @(posedge aclk) begin
        if (ld[1]) begin
            mode1_reg <= s_mode;
            x1_reg    <= s_x_coord;
            y1_reg    <= s_y_coord;
            idx1_reg  <= s_entry_index;
            val1_reg  <= s_entry_value;
        end
        if (ld[2]) begin
            mode2_reg <= mode1_reg;
        end
    end

    // Table writes land as the write beat passes each copy's read stage
    assign wr.we_first  = v_reg[1] && (mode1_reg == MODE_WRITE) && ld[2];
    assign wr.we_second = v_reg[2] && (mode2_reg == MODE_WRITE) && ld[3];

    // Valid bits; write beats drop out after stage 2
    always_comb begin
        v_next = v_reg;
        if (ld[1]) begin
            v_next[1] = s_valid;
        end
        if (ld[2]) begin
            v_next[2] = v_reg[1];
        end
        if (ld[3]) begin
            v_next[3] = v_reg[2] && (mode2_reg == MODE_COMPUTE);
        end
        for (int k = 4; k <= NUM_STAGES; k++) begin
            if (ld[k]) begin
                v_next[k] = v_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    // Hashing and corner gradients
    logic signed [F+1:0] bl;
    logic signed [F+1:0] br;
    logic signed [F+2:0] dl;
    logic signed [F+2:0] dh;

    pnz_hash #(.TABLE_SIZE(TABLE_SIZE), .FRAC_BITS(FRAC_BITS)) u_hash (
        .aclk (aclk),
        .ld   (ld),
        .wr   (wr),
        .x1   (x1_reg),
        .y1   (y1_reg),
        .idx1 (idx1_reg),
        .val1 (val1_reg),
        .bl_o (bl),
        .br_o (br),
        .dl_o (dl),
        .dh_o (dh)
    );

    // Fade weights for each axis
    logic signed [F+1:0] fade_u;
    logic signed [F+1:0] fade_v;

    pnz_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_x (
        .aclk   (aclk),
        .ld     (ld),
        .t      (x1_reg[F-1:0]),
        .fade_o (fade_u)
    );

    pnz_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_y (
        .aclk   (aclk),
        .ld     (ld),
        .t      (y1_reg[F-1:0]),
        .fade_o (fade_v)
    );

    // Blend and output register
    pnz_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
        .aclk    (aclk),
        .ld      (ld),
        .bl      (bl),
        .br      (br),
        .dl      (dl),
        .dh      (dh),
        .u       (fade_u),
        .v       (fade_v),
        .noise_o (m_noise_value)
    );

    assign m_valid = v_reg[NUM_STAGES];

`ifndef SYNTHESIS
    // Input backpressure only when every stage holds a beat
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (&v_reg))
        else $error("input stalled with a bubble in the pipeline");

    // A table-write beat never becomes a result
    a_write_drops: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[2] && (mode2_reg == MODE_WRITE) && ld[3]) |=> !v_reg[3])
        else $error("table-write beat passed the hash stage");

    // A beat loaded into the output stage is presented next cycle
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[NUM_STAGES-1] && ld[NUM_STAGES]) |=> m_valid)
        else $error("result beat lost at the output stage");
`endif

endmodule

>>> rtl/core/pnz_ram.sv
// ----------------------------------------------------------------------------
// pnz_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module pnz_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_a_reg <= mem_reg[raddr_a];
            rdata_b_reg <= mem_reg[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

>>> rtl/core/pnz_hash.sv
// ----------------------------------------------------------------------------
// pnz_hash
// Cell lookup: two hash rounds through the permutation table copies, then
// the four corner gradient dot products (stages 2 to 4).
// ----------------------------------------------------------------------------
module pnz_hash
    import pnz_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  stage_ld_t                         ld,
    input  tbl_wr_t                           wr,
    input  logic signed [COORD_W-1:0]         x1,
    input  logic signed [COORD_W-1:0]         y1,
    input  logic [ENTRY_W-1:0]                idx1,
    input  logic [ENTRY_W-1:0]                val1,
    output logic signed [FRAC_BITS+1:0]       bl_o,
    output logic signed [FRAC_BITS+1:0]       br_o,
    output logic signed [FRAC_BITS+2:0]       dl_o,
    output logic signed [FRAC_BITS+2:0]       dh_o
);

    localparam int IW = $clog2(TABLE_SIZE);
    localparam int F  = FRAC_BITS;
    localparam int XW = COORD_W + IW;
    localparam int GW = F + 2;
    localparam int DW = F + 3;
    localparam logic signed [GW-1:0] ONE_G = GW'(1) <<< F;

    // Gradient selectors, low two bits of a corner hash
    localparam logic [1:0] GRAD_PP = 2'd0;
    localparam logic [1:0] GRAD_NP = 2'd1;
    localparam logic [1:0] GRAD_NN = 2'd2;
    localparam logic [1:0] GRAD_PN = 2'd3;

    function automatic logic signed [GW-1:0] grad_dot(
        input logic [1:0]           h,
        input logic signed [GW-1:0] dx,
        input logic signed [GW-1:0] dy
    );
        logic signed [GW-1:0] res;
        case (h)
            GRAD_PP: res = dx + dy;
            GRAD_NP: res = dy - dx;
            GRAD_NN: res = -dx - dy;
            GRAD_PN: res = dx - dy;
            default: res = dx - dy;
        endcase
        return res;
    endfunction

    // Stage 1: floored cell index, wrapped to the table
    logic signed [XW-1:0] x_ext;
    logic signed [XW-1:0] y_ext;
    logic [IW-1:0]        cx;

    assign x_ext = XW'(x1);
    assign y_ext = XW'(y1);
    assign cx    = x_ext[F +: IW];

    // Stage 2 registers
    logic [IW-1:0]      cy2_reg;
    logic [F-1:0]       fx2_reg;
    logic [F-1:0]       fy2_reg;
    logic [ENTRY_W-1:0] idx2_reg;
    logic [ENTRY_W-1:0] val2_reg;

    always_ff @(posedge aclk) begin
        if (ld[2]) begin
            cy2_reg  <= y_ext[F +: IW];
            fx2_reg  <= x1[F-1:0];
            fy2_reg  <= y1[F-1:0];
            idx2_reg <= idx1;
            val2_reg <= val1;
        end
    end

    // First hash round: perm[cx], perm[cx + 1]
    logic [ENTRY_W-1:0] px0;
    logic [ENTRY_W-1:0] px1;

    pnz_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_SIZE)) u_ram_x (
        .aclk    (aclk),
        .we      (wr.we_first),
        .waddr   (IW'(idx1)),
        .wdata   (val1),
        .re      (ld[2]),
        .raddr_a (cx),
        .raddr_b (cx + IW'(1)),
        .rdata_a (px0),
        .rdata_b (px1)
    );

    // Second hash round, two copies with two ports each
    logic [IW-1:0]      addr_l;
    logic [IW-1:0]      addr_r;
    logic [ENTRY_W-1:0] h_bl;
    logic [ENTRY_W-1:0] h_tl;
    logic [ENTRY_W-1:0] h_br;
    logic [ENTRY_W-1:0] h_tr;

    assign addr_l = IW'(px0) + cy2_reg;
    assign addr_r = IW'(px1) + cy2_reg;

    pnz_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_SIZE)) u_ram_l (
        .aclk    (aclk),
        .we      (wr.we_second),
        .waddr   (IW'(idx2_reg)),
        .wdata   (val2_reg),
        .re      (ld[3]),
        .raddr_a (addr_l),
        .raddr_b (addr_l + IW'(1)),
        .rdata_a (h_bl),
        .rdata_b (h_tl)
    );

    pnz_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_SIZE)) u_ram_r (
        .aclk    (aclk),
        .we      (wr.we_second),
        .waddr   (IW'(idx2_reg)),
        .wdata   (val2_reg),
        .re      (ld[3]),
        .raddr_a (addr_r),
        .raddr_b (addr_r + IW'(1)),
        .rdata_a (h_br),
        .rdata_b (h_tr)
    );

    // Stage 3 registers: fractions alongside the corner hashes
    logic [F-1:0] fx3_reg;
    logic [F-1:0] fy3_reg;

    always_ff @(posedge aclk) begin
        if (ld[3]) begin
            fx3_reg <= fx2_reg;
            fy3_reg <= fy2_reg;
        end
    end

    // Corner offsets and dot products
    logic signed [GW-1:0] dx0;
    logic signed [GW-1:0] dx1;
    logic signed [GW-1:0] dy0;
    logic signed [GW-1:0] dy1;
    logic signed [GW-1:0] g_bl;
    logic signed [GW-1:0] g_br;
    logic signed [GW-1:0] g_tl;
    logic signed [GW-1:0] g_tr;

    assign dx0  = $signed(GW'(fx3_reg));
    assign dy0  = $signed(GW'(fy3_reg));
    assign dx1  = dx0 - ONE_G;
    assign dy1  = dy0 - ONE_G;
    assign g_bl = grad_dot(h_bl[1:0], dx0, dy0);
    assign g_br = grad_dot(h_br[1:0], dx1, dy0);
    assign g_tl = grad_dot(h_tl[1:0], dx0, dy1);
    assign g_tr = grad_dot(h_tr[1:0], dx1, dy1);

    // Stage 4 registers: bottom corners and vertical differences
    logic signed [GW-1:0] bl_reg;
    logic signed [GW-1:0] br_reg;
    logic signed [DW-1:0] dl_reg;
    logic signed [DW-1:0] dh_reg;

    always_ff @(posedge aclk) begin
        if (ld[4]) begin
            bl_reg <= g_bl;
            br_reg <= g_br;
            dl_reg <= DW'(g_tl) - DW'(g_bl);
            dh_reg <= DW'(g_tr) - DW'(g_br);
        end
    end

    assign bl_o = bl_reg;
    assign br_o = br_reg;
    assign dl_o = dl_reg;
    assign dh_o = dh_reg;

endmodule

>>> rtl/core/pnz_fade.sv
// ----------------------------------------------------------------------------
// pnz_fade
// Quintic fade curve for one axis, three multiply stages (stages 2 to 4).
// ----------------------------------------------------------------------------
module pnz_fade
    import pnz_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  stage_ld_t                   ld,
    input  logic [FRAC_BITS-1:0]        t,
    output logic signed [FRAC_BITS+1:0] fade_o
);

    localparam int F  = FRAC_BITS;
    localparam int AW = F + 5;
    localparam int PW = F + 1 + AW;
    localparam logic signed [AW-1:0] K6      = AW'(FADE_K6);
    localparam logic signed [AW-1:0] K15_ONE = AW'(FADE_K15) <<< F;
    localparam logic signed [AW-1:0] K10_ONE = AW'(FADE_K10) <<< F;

    // Stage 2: a*t and t*t, with a = 6t - 15
    logic signed [AW-1:0]   t_s;
    logic signed [AW-1:0]   a;
    logic signed [2*AW-1:0] at_reg;
    logic [2*F-1:0]         tt_reg;
    logic [F-1:0]           t2_reg;

    assign t_s = $signed(AW'(t));
    assign a   = t_s * K6 - K15_ONE;

    always_ff @(posedge aclk) begin
        if (ld[2]) begin
            at_reg <= a * t_s;
            tt_reg <= t * t;
            t2_reg <= t;
        end
    end

    // Stage 3: b = floor(a*t) + 10, d product = floor(t*t) * t
    logic signed [AW-1:0] b;
    logic signed [AW-1:0] b3_reg;
    logic [2*F-1:0]       dp3_reg;

    assign b = AW'(at_reg >>> F) + K10_ONE;

    always_ff @(posedge aclk) begin
        if (ld[3]) begin
            b3_reg  <= b;
            dp3_reg <= tt_reg[F +: F] * t2_reg;
        end
    end

    // Stage 4: floor(d) * b
    logic signed [F:0]    d_s;
    logic signed [PW-1:0] fp4_reg;

    assign d_s = $signed({1'b0, dp3_reg[F +: F]});

    always_ff @(posedge aclk) begin
        if (ld[4]) begin
            fp4_reg <= d_s * b3_reg;
        end
    end

    assign fade_o = $signed(fp4_reg[F +: F+2]);

endmodule

>>> rtl/core/pnz_blend.sv
// ----------------------------------------------------------------------------
// pnz_blend
// Bilinear blend of the corner values by the faded weights, output scaling
// and saturation (stages 5 to 8).
// ----------------------------------------------------------------------------
module pnz_blend
    import pnz_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  stage_ld_t                   ld,
    input  logic signed [FRAC_BITS+1:0] bl,
    input  logic signed [FRAC_BITS+1:0] br,
    input  logic signed [FRAC_BITS+2:0] dl,
    input  logic signed [FRAC_BITS+2:0] dh,
    input  logic signed [FRAC_BITS+1:0] u,
    input  logic signed [FRAC_BITS+1:0] v,
    output logic signed [OUT_W-1:0]     noise_o
);

    localparam int F   = FRAC_BITS;
    localparam int FW  = F + 2;
    localparam int GW  = F + 2;
    localparam int DW  = F + 3;
    localparam int LW  = F + 4;
    localparam int RW  = F + 5;
    localparam int SW  = RW + 8;
    localparam int SHR = (F > OUT_FRAC) ? F - OUT_FRAC : 0;
    localparam int SHL = (F < OUT_FRAC) ? OUT_FRAC - F : 0;
    localparam logic signed [SW-1:0] SAT_MAX = SW'(OUT_MAX);
    localparam logic signed [SW-1:0] SAT_MIN = SW'(OUT_MIN);

    // Stage 5: vertical products v * (top - bottom)
    logic signed [FW+DW-1:0] plo5_reg;
    logic signed [FW+DW-1:0] phi5_reg;
    logic signed [GW-1:0]    bl5_reg;
    logic signed [GW-1:0]    br5_reg;
    logic signed [FW-1:0]    u5_reg;

    always_ff @(posedge aclk) begin
        if (ld[5]) begin
            plo5_reg <= v * dl;
            phi5_reg <= v * dh;
            bl5_reg  <= bl;
            br5_reg  <= br;
            u5_reg   <= u;
        end
    end

    // Stage 6: left and right edge values, horizontal difference
    logic signed [LW-1:0] lo;
    logic signed [LW-1:0] hi;
    logic signed [LW-1:0] lo6_reg;
    logic signed [LW:0]   dlh6_reg;
    logic signed [FW-1:0] u6_reg;

    assign lo = LW'(bl5_reg) + $signed(plo5_reg[F +: LW]);
    assign hi = LW'(br5_reg) + $signed(phi5_reg[F +: LW]);

    always_ff @(posedge aclk) begin
        if (ld[6]) begin
            lo6_reg  <= lo;
            dlh6_reg <= (LW+1)'(hi) - (LW+1)'(lo);
            u6_reg   <= u5_reg;
        end
    end

    // Stage 7: horizontal product u * (hi - lo)
    logic signed [FW+LW:0] pr7_reg;
    logic signed [LW-1:0]  lo7_reg;

    always_ff @(posedge aclk) begin
        if (ld[7]) begin
            pr7_reg <= u6_reg * dlh6_reg;
            lo7_reg <= lo6_reg;
        end
    end

    // Stage 8: final sum, rescale to the output fraction, saturate
    logic signed [RW-1:0]    r;
    logic signed [SW-1:0]    r_scaled;
    logic signed [OUT_W-1:0] r_sat;
    logic signed [OUT_W-1:0] noise_reg;

    assign r        = RW'(lo7_reg) + $signed(pr7_reg[F +: RW]);
    assign r_scaled = (SW'(r) >>> SHR) <<< SHL;

    always_comb begin
        if (r_scaled > SAT_MAX) begin
            r_sat = SAT_MAX[OUT_W-1:0];
        end else if (r_scaled < SAT_MIN) begin
            r_sat = SAT_MIN[OUT_W-1:0];
        end else begin
            r_sat = r_scaled[OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[8]) begin
            noise_reg <= r_sat;
        end
    end

    assign noise_o = noise_reg;

endmodule
